>>> rtl/core/rbds_pkg.sv
// Shared types, constants and arithmetic helpers of the rigid body derived state core.
`timescale 1ns / 1ps
`default_nettype none

package rbds_pkg;

    // Word formats.
    localparam int DATA_W = 32;
    localparam int QFRAC  = 30;
    localparam int VFRAC  = 16;
    localparam int ADDR_W = 5;

    // Raw Q6.60 image of the squared length threshold.
    localparam logic [65:0] EPS_LEN_SQ = 66'd115;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_INV_MASS = 3'd0;
    localparam logic [2:0] REG_IXX      = 3'd1;
    localparam logic [2:0] REG_IYY      = 3'd2;
    localparam logic [2:0] REG_IZZ      = 3'd3;
    localparam logic [2:0] REG_IXY      = 3'd4;
    localparam logic [2:0] REG_IXZ      = 3'd5;
    localparam logic [2:0] REG_IYZ      = 3'd6;

    // Reset values of the registers.
    localparam logic [30:0]        INV_MASS_RST = 31'd65536;
    localparam logic signed [31:0] DIAG_RST     = 32'sd65536;
    localparam logic signed [31:0] OFF_RST      = 32'sd0;

    typedef logic signed [DATA_W-1:0] t_word;

    // Values that travel alongside the arithmetic from entry to exit.
    typedef struct {
        t_word q   [4];
        t_word vel [3];
        t_word l   [3];
        logic  norm;
    } t_side;

    // One result transaction.
    typedef struct {
        t_word nq    [4];
        t_word vel   [3];
        t_word omega [3];
    } t_result;

    // Square root iteration state.
    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } t_sqrt;

    // Long division iteration state.
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } t_div;

    // Full-precision signed product of two words.
    function automatic logic signed [63:0] mul(input t_word a, input t_word b);
        return 64'(a) * 64'(b);
    endfunction

    // Magnitude of a word; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(input t_word v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Saturation to the signed word range.
    function automatic t_word sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Round half up by the quaternion fraction bits.
    function automatic logic signed [34:0] rnd_q(input logic signed [63:0] p);
        logic signed [64:0] e;
        e = 65'(p) + (65'sd1 <<< (QFRAC - 1));
        return 35'(e >>> QFRAC);
    endfunction

    // Round half up by the value fraction bits.
    function automatic logic signed [48:0] rnd_v(input logic signed [63:0] p);
        logic signed [64:0] e;
        e = 65'(p) + (65'sd1 <<< (VFRAC - 1));
        return 49'(e >>> VFRAC);
    endfunction

    // Round a wide rotation term to Q2.30 and saturate.
    function automatic t_word rnd_sat_q(input logic signed [67:0] v);
        logic signed [67:0] e;
        e = v + (68'sd1 <<< (QFRAC - 1));
        return sat32(e >>> QFRAC);
    endfunction

    // Left shift that brings the largest magnitude into [2^30, 2^31].
    function automatic logic [4:0] lead_shift(input logic [31:0] m);
        logic [4:0] sh;
        sh = 5'd0;
        for (int b = 0; b < 30; b++) begin
            if (m[b]) begin
                sh = 5'(30 - b);
            end
        end
        if (m[31] || m[30]) begin
            sh = 5'd0;
        end
        return sh;
    endfunction

    // One result bit of the digit-by-digit square root.
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       o;
        logic [34:0] rn;
        logic [34:0] trial;
        rn    = {s.rem[32:0], s.rad[63:62]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (rn >= trial) begin
            o.rem  = rn - trial;
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = rn;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // Four square root bits, one pipeline stage.
    function automatic t_sqrt sqrt4(input t_sqrt s);
        t_sqrt o;
        o = s;
        for (int k = 0; k < 4; k++) begin
            o = sqrt_step(o);
        end
        return o;
    endfunction

    // One quotient bit of the restoring division.
    function automatic t_div div_step(input t_div d, input logic [32:0] len);
        t_div        o;
        logic [33:0] t;
        t     = {d.rem, d.low[31]};
        o.low = {d.low[30:0], 1'b0};
        if (t >= {1'b0, len}) begin
            o.rem = 33'(t - {1'b0, len});
            o.quo = {d.quo[30:0], 1'b1};
        end else begin
            o.rem = t[32:0];
            o.quo = {d.quo[30:0], 1'b0};
        end
        return o;
    endfunction

    // Four quotient bits, one pipeline stage.
    function automatic t_div div4(input t_div d, input logic [32:0] len);
        t_div o;
        o = d;
        for (int k = 0; k < 4; k++) begin
            o = div_step(o, len);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rigid_body_derived_state_core.sv
// Rigid body derived state: normalised quaternion, linear and angular velocity.
// Use: one body state (quaternion, linear and angular momentum) enters on the input
// channel; one transaction leaves with the normalised quaternion, v = P * inv_mass
// and omega = (R * Ib * R^T) * L. Both channels use valid and stall; a transaction
// moves at a clock edge with valid high and stall low.
// Throughput: one transaction per cycle, limited by nothing but output stalls.
// Stages: the 33-stage pipeline holds 8 square root stages and 8 division stages
// of four bits each, then the rotation and inertia product stages with at most one
// multiplier level per stage.
// Stall: when the receiver stalls, results collect in the output register and one
// skid register; o_stall rises only once the skid register is full, and then the
// whole pipeline holds until the output is taken.
// Reset: i_rst_n is synchronous and active low; it empties the pipeline and the
// output registers and loads inv_mass = 1.0, diagonal inertia 1.0 and zero off-diagonals.
// Configuration: APB registers at byte addresses 4*i, written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rigid_body_derived_state_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [rbds_pkg::ADDR_W-1:0]         paddr,
    input  wire [31:0]                         pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire signed [31:0]                  i_quat_w,
    input  wire signed [31:0]                  i_quat_x,
    input  wire signed [31:0]                  i_quat_y,
    input  wire signed [31:0]                  i_quat_z,
    input  wire signed [31:0]                  i_lin_mom_x,
    input  wire signed [31:0]                  i_lin_mom_y,
    input  wire signed [31:0]                  i_lin_mom_z,
    input  wire signed [31:0]                  i_ang_mom_x,
    input  wire signed [31:0]                  i_ang_mom_y,
    input  wire signed [31:0]                  i_ang_mom_z,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [31:0]                 o_norm_quat_w,
    output logic signed [31:0]                 o_norm_quat_x,
    output logic signed [31:0]                 o_norm_quat_y,
    output logic signed [31:0]                 o_norm_quat_z,
    output logic signed [31:0]                 o_vel_x,
    output logic signed [31:0]                 o_vel_y,
    output logic signed [31:0]                 o_vel_z,
    output logic signed [31:0]                 o_omega_x,
    output logic signed [31:0]                 o_omega_y,
    output logic signed [31:0]                 o_omega_z
);

    // Pipeline stage positions.
    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_H0 = 7;
    localparam int ST_P  = 15;
    localparam int ST_D0 = 16;
    localparam int ST_N  = 24;
    localparam int NSTG  = 33;
    localparam int LAST  = NSTG - 1;
    localparam int NSQ   = ST_P - ST_H0;
    localparam int NDV   = ST_N - ST_D0;

    // Product slots of the rotation stage.
    localparam int PXX = 0;
    localparam int PYY = 1;
    localparam int PZZ = 2;
    localparam int PXY = 3;
    localparam int PZW = 4;
    localparam int PXZ = 5;
    localparam int PYW = 6;
    localparam int PYZ = 7;
    localparam int PXW = 8;

    // Configuration registers.
    logic [30:0]     r_inv_mass;
    rbds_pkg::t_word r_ixx, r_iyy, r_izz, r_ixy, r_ixz, r_iyz;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rbds_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass <= rbds_pkg::INV_MASS_RST;
            r_ixx      <= rbds_pkg::DIAG_RST;
            r_iyy      <= rbds_pkg::DIAG_RST;
            r_izz      <= rbds_pkg::DIAG_RST;
            r_ixy      <= rbds_pkg::OFF_RST;
            r_ixz      <= rbds_pkg::OFF_RST;
            r_iyz      <= rbds_pkg::OFF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                rbds_pkg::REG_INV_MASS: r_inv_mass <= pwdata[30:0];
                rbds_pkg::REG_IXX:      r_ixx      <= pwdata;
                rbds_pkg::REG_IYY:      r_iyy      <= pwdata;
                rbds_pkg::REG_IZZ:      r_izz      <= pwdata;
                rbds_pkg::REG_IXY:      r_ixy      <= pwdata;
                rbds_pkg::REG_IXZ:      r_ixz      <= pwdata;
                rbds_pkg::REG_IYZ:      r_iyz      <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            rbds_pkg::REG_INV_MASS: prdata = {1'b0, r_inv_mass};
            rbds_pkg::REG_IXX:      prdata = r_ixx;
            rbds_pkg::REG_IYY:      prdata = r_iyy;
            rbds_pkg::REG_IZZ:      prdata = r_izz;
            rbds_pkg::REG_IXY:      prdata = r_ixy;
            rbds_pkg::REG_IXZ:      prdata = r_ixz;
            rbds_pkg::REG_IYZ:      prdata = r_iyz;
            default:                prdata = 32'd0;
        endcase
    end

    // Symmetric body inverse inertia.
    rbds_pkg::t_word ib [3][3];
    always_comb begin
        ib[0][0] = r_ixx; ib[1][1] = r_iyy; ib[2][2] = r_izz;
        ib[0][1] = r_ixy; ib[1][0] = r_ixy;
        ib[0][2] = r_ixz; ib[2][0] = r_ixz;
        ib[1][2] = r_iyz; ib[2][1] = r_iyz;
    end

    // Flow control: the pipeline moves unless the skid register is occupied.
    logic               r_out_vld, r_skid_vld;
    logic [NSTG-1:0]    r_vld;
    logic               en, in_acc;

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign in_acc  = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], in_acc};
        end
    end

    // Input gathering.
    rbds_pkg::t_word in_q [4];
    rbds_pkg::t_word in_p [3];
    rbds_pkg::t_side n_side0;
    always_comb begin
        in_q[0] = i_quat_w; in_q[1] = i_quat_x; in_q[2] = i_quat_y; in_q[3] = i_quat_z;
        in_p[0] = i_lin_mom_x; in_p[1] = i_lin_mom_y; in_p[2] = i_lin_mom_z;
        n_side0.q    = in_q;
        n_side0.l[0] = i_ang_mom_x;
        n_side0.l[1] = i_ang_mom_y;
        n_side0.l[2] = i_ang_mom_z;
        n_side0.vel  = '{default: '0};
        n_side0.norm = 1'b0;
    end

    // Stage registers.
    rbds_pkg::t_side    r_side [NSTG];
    logic [31:0]        r_a_mag [4], r_b_mag [4], r_c_mag [4], r_d_mag [4];
    logic signed [63:0] r_a_velp [3];
    logic [63:0]        r_b_sq [4], r_f_sq [4];
    logic [31:0]        r_c_max;
    logic [4:0]         r_d_sh;
    logic [31:0]        r_e_ms [4], r_f_ms [4], r_g_ms [4];
    logic [63:0]        r_g_rad;
    logic               r_g_big;
    rbds_pkg::t_sqrt    r_h_st [NSQ];
    logic [31:0]        r_h_ms [NSQ][4];
    logic               r_h_big [NSQ];
    rbds_pkg::t_div     r_p_div [4];
    logic [32:0]        r_p_len;
    rbds_pkg::t_div     r_dv [NDV][4];
    logic [32:0]        r_dv_len [NDV];
    logic signed [63:0] r_r1_p [9];
    rbds_pkg::t_word    r_rot [3][3], r_m1_rot [3][3], r_m2_rot [3][3];
    logic signed [63:0] r_m1_p [3][3][3], r_v1_p [3][3][3];
    rbds_pkg::t_word    r_m2_m [3][3], r_iv [3][3];
    logic signed [63:0] r_w1_p [3][3];
    rbds_pkg::t_word    r_omega [3];

    // Combinational helpers of a few stages.
    logic [65:0]        c_sum, g_sum;
    logic [31:0]        c_max01, c_max23;
    logic [32:0]        p_len;
    logic [61:0]        p_num [4];
    rbds_pkg::t_word    n_nq [4];
    logic [33:0]        n_sv [4];
    rbds_pkg::t_sqrt    h_init;

    always_comb begin
        c_sum   = 66'(r_b_sq[0]) + 66'(r_b_sq[1]) + 66'(r_b_sq[2]) + 66'(r_b_sq[3]);
        c_max01 = (r_b_mag[0] > r_b_mag[1]) ? r_b_mag[0] : r_b_mag[1];
        c_max23 = (r_b_mag[2] > r_b_mag[3]) ? r_b_mag[2] : r_b_mag[3];
        g_sum   = 66'(r_f_sq[0]) + 66'(r_f_sq[1]) + 66'(r_f_sq[2]) + 66'(r_f_sq[3]);
        h_init  = '{rad: r_g_rad, rem: 35'd0, root: 32'd0};
        p_len   = r_h_big[NSQ-1] ? {1'b1, 32'd0} : {1'b0, r_h_st[NSQ-1].root};
        for (int i = 0; i < 4; i++) begin
            p_num[i] = (62'(r_h_ms[NSQ-1][i]) << rbds_pkg::QFRAC) + 62'(p_len[32:1]);
            n_sv[i]  = r_side[ST_N-1].q[i][31] ? -34'(r_dv[NDV-1][i].quo)
                                               : 34'(r_dv[NDV-1][i].quo);
            n_nq[i]  = r_side[ST_N-1].norm ? rbds_pkg::sat32(68'($signed(n_sv[i])))
                                           : r_side[ST_N-1].q[i];
        end
    end

    // Side values: carried along, with velocity, the threshold flag and the
    // normalised quaternion filled in on the way.
    rbds_pkg::t_side n_side [NSTG];
    always_comb begin
        n_side[0] = n_side0;
        for (int s = 1; s < NSTG; s++) begin
            n_side[s] = r_side[s-1];
        end
        for (int i = 0; i < 3; i++) begin
            n_side[ST_B].vel[i] = rbds_pkg::sat32(68'(rbds_pkg::rnd_v(r_a_velp[i])));
        end
        n_side[ST_C].norm = (c_sum > rbds_pkg::EPS_LEN_SQ);
        n_side[ST_N].q    = n_nq;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side <= n_side;
        end
    end

    // Front end: magnitudes, squares, velocity products, largest magnitude, alignment shift.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_a_mag[i] <= rbds_pkg::mag32(in_q[i]);
                r_b_mag[i] <= r_a_mag[i];
                r_b_sq[i]  <= 64'(r_a_mag[i]) * 64'(r_a_mag[i]);
                r_c_mag[i] <= r_b_mag[i];
                r_d_mag[i] <= r_c_mag[i];
                r_e_ms[i]  <= 32'(r_d_mag[i] << r_d_sh);
                r_f_ms[i]  <= r_e_ms[i];
                r_f_sq[i]  <= 64'(r_e_ms[i]) * 64'(r_e_ms[i]);
                r_g_ms[i]  <= r_f_ms[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_a_velp[i] <= rbds_pkg::mul(in_p[i], $signed({1'b0, r_inv_mass}));
            end
            r_c_max <= (c_max01 > c_max23) ? c_max01 : c_max23;
            r_d_sh  <= rbds_pkg::lead_shift(r_c_max);
            r_g_rad <= g_sum[63:0];
            r_g_big <= (g_sum[65:64] != 2'd0);
        end
    end

    // Square root of the aligned squared length, four bits per stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_st[0]  <= rbds_pkg::sqrt4(h_init);
            r_h_ms[0]  <= r_g_ms;
            r_h_big[0] <= r_g_big;
            for (int k = 1; k < NSQ; k++) begin
                r_h_st[k]  <= rbds_pkg::sqrt4(r_h_st[k-1]);
                r_h_ms[k]  <= r_h_ms[k-1];
                r_h_big[k] <= r_h_big[k-1];
            end
        end
    end

    // Division of each aligned component by the length, four bits per stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_len <= p_len;
            for (int i = 0; i < 4; i++) begin
                r_p_div[i] <= '{rem: {3'd0, p_num[i][61:32]}, low: p_num[i][31:0],
                                quo: 32'd0};
                r_dv[0][i] <= rbds_pkg::div4(r_p_div[i], r_p_len);
                for (int k = 1; k < NDV; k++) begin
                    r_dv[k][i] <= rbds_pkg::div4(r_dv[k-1][i], r_dv_len[k-1]);
                end
            end
            r_dv_len[0] <= r_p_len;
            for (int k = 1; k < NDV; k++) begin
                r_dv_len[k] <= r_dv_len[k-1];
            end
        end
    end

    // Rotation matrix: quaternion products, then sums rounded to Q2.30.
    rbds_pkg::t_word nw, nx, ny, nz;
    assign nw = r_side[ST_N].q[0];
    assign nx = r_side[ST_N].q[1];
    assign ny = r_side[ST_N].q[2];
    assign nz = r_side[ST_N].q[3];

    logic signed [67:0] one_q;
    assign one_q = 68'sd1 <<< (2 * rbds_pkg::QFRAC);

    function automatic logic signed [67:0] twice(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic               sub);
        logic signed [67:0] s;
        s = sub ? (68'(a) - 68'(b)) : (68'(a) + 68'(b));
        return s <<< 1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1_p[PXX] <= rbds_pkg::mul(nx, nx);
            r_r1_p[PYY] <= rbds_pkg::mul(ny, ny);
            r_r1_p[PZZ] <= rbds_pkg::mul(nz, nz);
            r_r1_p[PXY] <= rbds_pkg::mul(nx, ny);
            r_r1_p[PZW] <= rbds_pkg::mul(nz, nw);
            r_r1_p[PXZ] <= rbds_pkg::mul(nx, nz);
            r_r1_p[PYW] <= rbds_pkg::mul(ny, nw);
            r_r1_p[PYZ] <= rbds_pkg::mul(ny, nz);
            r_r1_p[PXW] <= rbds_pkg::mul(nx, nw);

            r_rot[0][0] <= rbds_pkg::rnd_sat_q(one_q - twice(r_r1_p[PYY], r_r1_p[PZZ], 1'b0));
            r_rot[0][1] <= rbds_pkg::rnd_sat_q(twice(r_r1_p[PXY], r_r1_p[PZW], 1'b0));
            r_rot[0][2] <= rbds_pkg::rnd_sat_q(twice(r_r1_p[PXZ], r_r1_p[PYW], 1'b1));
            r_rot[1][0] <= rbds_pkg::rnd_sat_q(twice(r_r1_p[PXY], r_r1_p[PZW], 1'b1));
            r_rot[1][1] <= rbds_pkg::rnd_sat_q(one_q - twice(r_r1_p[PXX], r_r1_p[PZZ], 1'b0));
            r_rot[1][2] <= rbds_pkg::rnd_sat_q(twice(r_r1_p[PYZ], r_r1_p[PXW], 1'b0));
            r_rot[2][0] <= rbds_pkg::rnd_sat_q(twice(r_r1_p[PXZ], r_r1_p[PYW], 1'b0));
            r_rot[2][1] <= rbds_pkg::rnd_sat_q(twice(r_r1_p[PYZ], r_r1_p[PXW], 1'b1));
            r_rot[2][2] <= rbds_pkg::rnd_sat_q(one_q - twice(r_r1_p[PXX], r_r1_p[PYY], 1'b0));
        end
    end

    // World inverse inertia: M = R * Ib, then Iinv = M * R^T, each a product
    // stage followed by a round-and-sum stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_rot <= r_rot;
            r_m2_rot <= r_m1_rot;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_m1_p[i][j][k] <= rbds_pkg::mul(r_rot[i][k], ib[k][j]);
                        r_v1_p[i][j][k] <= rbds_pkg::mul(r_m2_m[i][k], r_m2_rot[j][k]);
                    end
                    r_m2_m[i][j] <= rbds_pkg::sat32(68'(rbds_pkg::rnd_q(r_m1_p[i][j][0]))
                                                  + 68'(rbds_pkg::rnd_q(r_m1_p[i][j][1]))
                                                  + 68'(rbds_pkg::rnd_q(r_m1_p[i][j][2])));
                    r_iv[i][j]   <= rbds_pkg::sat32(68'(rbds_pkg::rnd_q(r_v1_p[i][j][0]))
                                                  + 68'(rbds_pkg::rnd_q(r_v1_p[i][j][1]))
                                                  + 68'(rbds_pkg::rnd_q(r_v1_p[i][j][2])));
                end
            end
        end
    end

    // Angular velocity: omega = Iinv * L.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_w1_p[i][j] <= rbds_pkg::mul(r_iv[i][j], r_side[ST_N + 6].l[j]);
                end
                r_omega[i] <= rbds_pkg::sat32(68'(rbds_pkg::rnd_v(r_w1_p[i][0]))
                                            + 68'(rbds_pkg::rnd_v(r_w1_p[i][1]))
                                            + 68'(rbds_pkg::rnd_v(r_w1_p[i][2])));
            end
        end
    end

    // Output register with a skid register behind it.
    rbds_pkg::t_result pipe_res, r_out, r_skid;
    always_comb begin
        pipe_res.nq    = r_side[LAST].q;
        pipe_res.vel   = r_side[LAST].vel;
        pipe_res.omega = r_omega;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || !i_stall) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= r_vld[LAST];
            end
        end else if (r_vld[LAST] && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || !i_stall) begin
            r_out <= r_skid_vld ? r_skid : pipe_res;
        end
        if (r_out_vld && i_stall && !r_skid_vld) begin
            r_skid <= pipe_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_norm_quat_w = r_out.nq[0];
    assign o_norm_quat_x = r_out.nq[1];
    assign o_norm_quat_y = r_out.nq[2];
    assign o_norm_quat_z = r_out.nq[3];
    assign o_vel_x       = r_out.vel[0];
    assign o_vel_y       = r_out.vel[1];
    assign o_vel_z       = r_out.vel[2];
    assign o_omega_x     = r_out.omega[0];
    assign o_omega_y     = r_out.omega[1];
    assign o_omega_z     = r_out.omega[2];

    // The skid register is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a transaction while the output is empty");

    // The skid register fills only when the output was stalled.
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_stall))
        else $error("skid register filled without an output stall");

    // While the skid register is full the pipeline holds its valid bits.
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> r_vld == $past(r_vld))
        else $error("pipeline moved while the skid register was full");

    // An item accepted at the input is in the first stage afterwards.
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[ST_A])
        else $error("accepted transaction missing from the first stage");

endmodule

`default_nettype wire
